### sv/dcpec_pkg.sv
// Shared constants, codes and CRC step functions of the daisy-chain PEC unit.
package dcpec_pkg;

  // Default sizes handed to the top level.
  localparam int DefDataBytes = 6;
  localparam int DefPorts     = 2;

  // Fixed field widths.
  localparam int CmdW   = 16;
  localparam int FrameW = 48;
  localparam int CrcW   = 10;
  localparam int CntW   = 6;

  // Command PEC: 16-bit register, MSB first.
  localparam logic [CmdW-1:0] CmdSeed = 16'h0020;
  localparam logic [CmdW-1:0] CmdPoly = 16'h8B32;

  // Data PEC: 10-bit register, MSB first.
  localparam logic [CrcW-1:0] DatSeed = 10'h010;
  localparam logic [CrcW-1:0] DatPoly = 10'h08F;

  // Counter wraps from this value back to one.
  localparam logic [CntW-1:0] CntMax = 6'd63;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_CMD_PEC  = 3'd0,
    OP_DATA_PEC = 3'd1,
    OP_CHECK    = 3'd2,
    OP_ADVANCE  = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  // Per-frame status codes.
  localparam logic [1:0] FrmOk       = 2'd0;
  localparam logic [1:0] FrmCrcErr   = 2'd1;
  localparam logic [1:0] FrmMismatch = 2'd2;
  localparam logic [1:0] FrmPor      = 2'd3;

  // Merged set status codes, ordered by severity.
  localparam logic [1:0] SetOk     = 2'd0;
  localparam logic [1:0] SetCntErr = 2'd1;
  localparam logic [1:0] SetPor    = 2'd2;
  localparam logic [1:0] SetCrcErr = 2'd3;

  // Command PEC over one 16-bit word, high bit first.
  function automatic logic [CmdW-1:0] cmd_crc(input logic [CmdW-1:0] word);
    logic [CmdW-1:0] crc;
    logic            fb;
    crc = CmdSeed;
    for (int i = CmdW - 1; i >= 0; i--) begin
      fb  = crc[CmdW-1] ^ word[i];
      crc = {crc[CmdW-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ CmdPoly;
      end
    end
    return crc;
  endfunction

  // Data PEC advanced over one byte, high bit first.
  function automatic logic [CrcW-1:0] dat_byte(input logic [CrcW-1:0] crc_in,
                                                input logic [7:0]      value);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[CrcW-1] ^ value[i];
      crc = {crc[CrcW-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ DatPoly;
      end
    end
    return crc;
  endfunction

  // Data PEC advanced over the 6-bit command counter.
  function automatic logic [CrcW-1:0] dat_count(input logic [CrcW-1:0] crc_in,
                                                 input logic [CntW-1:0] value);
    logic [CrcW-1:0] crc;
    logic            fb;
    crc = crc_in;
    for (int i = CntW - 1; i >= 0; i--) begin
      fb  = crc[CrcW-1] ^ value[i];
      crc = {crc[CrcW-2:0], 1'b0};
      if (fb) begin
        crc = crc ^ DatPoly;
      end
    end
    return crc;
  endfunction

endpackage

### sv/dcpec_pec.sv
// Combinational PEC generator: command PEC and the two data PEC variants.
module dcpec_pec #(
  parameter int DATA_BYTES = dcpec_pkg::DefDataBytes
) (
  input  logic [dcpec_pkg::CmdW-1:0]   command_word_i,
  input  logic [dcpec_pkg::FrameW-1:0] frame_data_i,
  input  logic [dcpec_pkg::CntW-1:0]   rx_count_i,
  output logic [dcpec_pkg::CmdW-1:0]   cmd_pec_o,
  output logic [dcpec_pkg::CrcW-1:0]   data_pec_zero_o,
  output logic [dcpec_pkg::CrcW-1:0]   data_pec_rx_o
);

  localparam int DataW = DATA_BYTES * 8;

  logic [DataW-1:0]             data_sel;
  logic [dcpec_pkg::CrcW-1:0]   data_crc;

  // Take the bytes that the frame carries; missing high bytes read as zero.
  generate
    if (DataW <= dcpec_pkg::FrameW) begin : g_trim
      assign data_sel = frame_data_i[DataW-1:0];
    end else begin : g_pad
      assign data_sel = {{(DataW - dcpec_pkg::FrameW){1'b0}}, frame_data_i};
    end
  endgenerate

  // XOR tree over the data bytes, first byte in the top bits.
  always_comb begin
    data_crc = dcpec_pkg::DatSeed;
    for (int i = DATA_BYTES - 1; i >= 0; i--) begin
      data_crc = dcpec_pkg::dat_byte(data_crc, data_sel[8*i +: 8]);
    end
  end

  // Counter tails: zero for write data, the received counter for checks.
  assign data_pec_zero_o = dcpec_pkg::dat_count(data_crc, '0);
  assign data_pec_rx_o   = dcpec_pkg::dat_count(data_crc, rx_count_i);

  assign cmd_pec_o = dcpec_pkg::cmd_crc(command_word_i);

endmodule

### sv/daisy_chain_pec_unit.sv
// Top level of the daisy-chain PEC unit: request registers, state and result register.
//
// Each request passes through combinational logic between an input register and a
// result register, and a new request is taken every cycle while the result register
// is free or being drained; a result is valid on the master side once its request
// has moved from the input register into the result register. The PEC logic unrolls
// both CRCs into XOR trees, and the command counters and sticky set status are
// updated as a request moves into the result register, so back-to-back requests see
// the effect of the one before. The input register accepts while it is empty, or
// while its request moves on because the result register is free or being drained.
module daisy_chain_pec_unit #(
  parameter int DATA_BYTES = dcpec_pkg::DefDataBytes,
  parameter int PORTS      = dcpec_pkg::DefPorts
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] command_word, [63:16] frame_data, [79:64] frame_pec
  input  logic [79:0] s_axis_tdata,
  // [2:0] op, [3] port, [4] both_ports, [5] first_frame
  input  logic [5:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] pec_out, [17:16] frame_status, [19:18] set_status,
  // [25:20] counter_seen, [31:26] local_count, [79:32] checked_data
  output logic [79:0] m_axis_tdata
);

  localparam int PortW = (PORTS > 1) ? $clog2(PORTS) : 1;

  // Input register.
  logic        in_valid_q;
  logic [79:0] in_data_q;
  logic [5:0]  in_user_q;
  logic        advance;

  // Result register.
  logic        out_valid_q;
  logic [79:0] out_data_q, out_data_d;

  // State.
  logic [dcpec_pkg::CntW-1:0] cnt_q [PORTS];
  logic [dcpec_pkg::CntW-1:0] cnt_d [PORTS];
  logic [1:0]                 merged_q, merged_d;

  // Decoded request fields.
  logic [2:0]                   op;
  logic [0:0]                   port;
  logic                         both;
  logic                         first;
  logic [dcpec_pkg::CmdW-1:0]   cmd_word;
  logic [dcpec_pkg::FrameW-1:0] frame_data;
  logic [15:0]                  frame_pec;
  logic [dcpec_pkg::CntW-1:0]   rx_cnt;
  logic [PortW-1:0]             sel;

  logic [dcpec_pkg::CmdW-1:0] cmd_pec;
  logic [dcpec_pkg::CrcW-1:0] pec_zero, pec_rx;

  logic [15:0]                  pec_out;
  logic [1:0]                   frm_stat;
  logic [1:0]                   code;
  logic [1:0]                   base;
  logic [dcpec_pkg::CntW-1:0]   seen;
  logic [dcpec_pkg::FrameW-1:0] cdata;
  logic                         hit_port;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign op         = in_user_q[2:0];
  assign port       = in_user_q[3];
  assign both       = in_user_q[4];
  assign first      = in_user_q[5];
  assign cmd_word   = in_data_q[15:0];
  assign frame_data = in_data_q[63:16];
  assign frame_pec  = in_data_q[79:64];
  assign rx_cnt     = frame_pec[15:10];

  // Clamp the port to the last one that exists.
  always_comb begin
    if (PORTS > 1) begin
      sel = PortW'(port);
    end else begin
      sel = '0;
    end
  end

  dcpec_pec #(
    .DATA_BYTES(DATA_BYTES)
  ) u_pec (
    .command_word_i (cmd_word),
    .frame_data_i   (frame_data),
    .rx_count_i     (rx_cnt),
    .cmd_pec_o      (cmd_pec),
    .data_pec_zero_o(pec_zero),
    .data_pec_rx_o  (pec_rx)
  );

  // Operation decode, state update and result assembly.
  always_comb begin
    pec_out  = '0;
    frm_stat = dcpec_pkg::FrmOk;
    code     = dcpec_pkg::SetOk;
    seen     = '0;
    cdata    = '0;
    merged_d = merged_q;
    hit_port = 1'b0;
    base     = first ? dcpec_pkg::SetOk : merged_q;
    for (int p = 0; p < PORTS; p++) begin
      cnt_d[p] = cnt_q[p];
    end
    case (dcpec_pkg::op_e'(op))
      dcpec_pkg::OP_CMD_PEC: begin
        pec_out = cmd_pec;
      end
      dcpec_pkg::OP_DATA_PEC: begin
        pec_out = {6'd0, pec_zero};
      end
      dcpec_pkg::OP_CHECK: begin
        seen = rx_cnt;
        if (pec_rx != frame_pec[9:0]) begin
          frm_stat = dcpec_pkg::FrmCrcErr;
          code     = dcpec_pkg::SetCrcErr;
        end else begin
          cdata = frame_data;
          if (rx_cnt != cnt_q[sel]) begin
            if (rx_cnt == '0) begin
              frm_stat = dcpec_pkg::FrmPor;
              code     = dcpec_pkg::SetPor;
            end else begin
              frm_stat = dcpec_pkg::FrmMismatch;
              code     = dcpec_pkg::SetCntErr;
            end
          end
        end
        merged_d = (code > base) ? code : base;
      end
      dcpec_pkg::OP_ADVANCE: begin
        for (int p = 0; p < PORTS; p++) begin
          hit_port = (PortW'(p) == sel) || both;
          if (hit_port) begin
            cnt_d[p] = (cnt_q[p] == dcpec_pkg::CntMax) ? 6'd1 : cnt_q[p] + 6'd1;
          end
        end
      end
      dcpec_pkg::OP_CLEAR: begin
        for (int p = 0; p < PORTS; p++) begin
          hit_port = (PortW'(p) == sel) || both;
          if (hit_port) begin
            cnt_d[p] = '0;
          end
        end
      end
      default: begin
        pec_out = '0;
      end
    endcase
    out_data_d = {cdata, cnt_d[sel], seen, merged_d, frm_stat, pec_out};
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      merged_q    <= dcpec_pkg::SetOk;
      for (int p = 0; p < PORTS; p++) begin
        cnt_q[p] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        merged_q    <= merged_d;
        for (int p = 0; p < PORTS; p++) begin
          cnt_q[p] <= cnt_d[p];
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### test/tb_daisy_chain_pec_unit.sv
// Testbench for the daisy-chain PEC unit: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_daisy_chain_pec_unit;

  // Result layout on the master-side data bus, highest field first.
  typedef struct packed {
    logic [47:0] checked_data;
    logic [5:0]  local_count;
    logic [5:0]  counter_seen;
    logic [1:0]  set_status;
    logic [1:0]  frame_status;
    logic [15:0] pec_out;
  } pec_result_t;

  // Operation codes the block does not define.
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;

  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [15:0] command_word, [63:16] frame_data, [79:64] frame_pec
  logic [79:0] s_axis_tdata;
  // [2:0] op, [3] port, [4] both_ports, [5] first_frame
  logic [5:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] pec_out, [17:16] frame_status, [19:18] set_status,
  // [25:20] counter_seen, [31:26] local_count, [79:32] checked_data
  logic [79:0] m_axis_tdata;

  // Predictor state: command counters per port and the sticky read-set status.
  logic [5:0]  local_cnt [2];
  logic [1:0]  set_stat;
  pec_result_t pec_result_q[$];

  int failures;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  daisy_chain_pec_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Command PEC over the 16-bit command word, high bit first.
  function automatic logic [15:0] command_pec(input logic [15:0] cmd);
    logic [15:0] r;
    r = dcpec_pkg::CmdSeed;
    for (int b = 15; b >= 0; b--) begin
      if (r[15] ^ cmd[b]) begin
        r = {r[14:0], 1'b0} ^ dcpec_pkg::CmdPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Data PEC over the six data bytes followed by the 6-bit counter, as one bit stream.
  function automatic logic [9:0] frame_crc(input logic [47:0] data, input logic [5:0] cnt);
    logic [53:0] stream;
    logic [9:0]  r;
    stream = {data, cnt};
    r      = dcpec_pkg::DatSeed;
    for (int b = 53; b >= 0; b--) begin
      if (r[9] ^ stream[b]) begin
        r = {r[8:0], 1'b0} ^ dcpec_pkg::DatPoly;
      end else begin
        r = {r[8:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Counter advance: the top value wraps back to one, never to zero.
  function automatic logic [5:0] next_count(input logic [5:0] c);
    return (c == dcpec_pkg::CntMax) ? 6'd1 : c + 6'd1;
  endfunction

  // Received PEC bytes of a well-formed frame with the given counter.
  function automatic logic [15:0] good_frame_pec(input logic [47:0] data, input logic [5:0] cnt);
    return {cnt, frame_crc(data, cnt)};
  endfunction

  function automatic logic [47:0] rand_data();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Works out the result of one accepted request and updates the predicted state.
  task automatic predict_pec_and_status(input logic [2:0] op, input logic port,
                                        input logic both, input logic first,
                                        input logic [15:0] cmd, input logic [47:0] data,
                                        input logic [15:0] rpec);
    pec_result_t res;
    logic [5:0]  cnt;
    logic [1:0]  code;
    res = '0;
    case (op)
      dcpec_pkg::OP_CMD_PEC: begin
        res.pec_out = command_pec(cmd);
      end
      dcpec_pkg::OP_DATA_PEC: begin
        res.pec_out = {6'd0, frame_crc(data, 6'd0)};
      end
      dcpec_pkg::OP_CHECK: begin
        cnt              = rpec[15:10];
        res.counter_seen = cnt;
        if (frame_crc(data, cnt) != rpec[9:0]) begin
          res.frame_status = dcpec_pkg::FrmCrcErr;
          code             = dcpec_pkg::SetCrcErr;
        end else begin
          res.checked_data = data;
          if (cnt == local_cnt[port]) begin
            code = dcpec_pkg::SetOk;
          end else if (cnt == 6'd0) begin
            res.frame_status = dcpec_pkg::FrmPor;
            code             = dcpec_pkg::SetPor;
          end else begin
            res.frame_status = dcpec_pkg::FrmMismatch;
            code             = dcpec_pkg::SetCntErr;
          end
        end
        // A new read set starts clean; otherwise the worse status sticks.
        if (first) begin
          set_stat = dcpec_pkg::SetOk;
        end
        if (code > set_stat) begin
          set_stat = code;
        end
      end
      dcpec_pkg::OP_ADVANCE: begin
        local_cnt[port] = next_count(local_cnt[port]);
        if (both) begin
          local_cnt[!port] = next_count(local_cnt[!port]);
        end
      end
      dcpec_pkg::OP_CLEAR: begin
        local_cnt[port] = 6'd0;
        if (both) begin
          local_cnt[!port] = 6'd0;
        end
      end
      default: begin
      end
    endcase
    res.set_status  = set_stat;
    res.local_count = local_cnt[port];
    pec_result_q.push_back(res);
  endtask

  // Sends one request, with random idle cycles first, and predicts it on acceptance.
  task automatic send_request(input logic [2:0] op, input logic port, input logic both,
                              input logic first, input logic [15:0] cmd,
                              input logic [47:0] data, input logic [15:0] rpec);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rpec, data, cmd};
    s_axis_tuser  <= {first, both, port, op};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    predict_pec_and_status(op, port, both, first, cmd, data, rpec);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pec_result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Command and data PEC at the extremes of their inputs.
  task automatic test_pec_ops();
    send_request(dcpec_pkg::OP_CMD_PEC, 1'b0, 1'b0, 1'b0, 16'h0000, '0, '0);
    send_request(dcpec_pkg::OP_CMD_PEC, 1'b1, 1'b1, 1'b1, 16'hFFFF, '1, '1);
    send_request(dcpec_pkg::OP_CMD_PEC, 1'b0, 1'b0, 1'b0, 16'h8001, '0, '0);
    send_request(dcpec_pkg::OP_DATA_PEC, 1'b0, 1'b0, 1'b0, '0, 48'h0, '0);
    send_request(dcpec_pkg::OP_DATA_PEC, 1'b1, 1'b1, 1'b1, '1, 48'hFFFF_FFFF_FFFF, '1);
    send_request(dcpec_pkg::OP_DATA_PEC, 1'b0, 1'b0, 1'b0, '0, 48'h8000_0000_0001, '0);
  endtask

  // Advance and clear on one port and on both, then the undefined operation codes.
  task automatic test_counter_ops();
    send_request(dcpec_pkg::OP_CLEAR, 1'b0, 1'b1, 1'b0, '0, '0, '0);
    send_request(dcpec_pkg::OP_ADVANCE, 1'b0, 1'b0, 1'b0, '0, '0, '0);
    send_request(dcpec_pkg::OP_ADVANCE, 1'b1, 1'b1, 1'b0, '0, '0, '0);
    send_request(dcpec_pkg::OP_ADVANCE, 1'b1, 1'b0, 1'b0, '0, '0, '0);
    send_request(dcpec_pkg::OP_CLEAR, 1'b1, 1'b0, 1'b0, '0, '0, '0);
    for (logic [3:0] u = {1'b0, OpSpareFirst}; u <= {1'b0, OpSpareLast}; u++) begin
      send_request(u[2:0], u[0], 1'b1, 1'b1, 16'($urandom()), rand_data(),
                   16'($urandom()));
    end
  endtask

  // Frame checks covering every status and the severity order of the set status.
  task automatic test_frame_checks();
    logic [47:0] d;
    d = rand_data();
    // Port A holds two after the counter test, port B zero.
    send_request(dcpec_pkg::OP_CHECK, 1'b0, 1'b0, 1'b1, '0, d, good_frame_pec(d, local_cnt[0]));
    send_request(dcpec_pkg::OP_CHECK, 1'b0, 1'b0, 1'b0, '0, d, good_frame_pec(d, 6'd63));
    send_request(dcpec_pkg::OP_CHECK, 1'b0, 1'b0, 1'b0, '0, d, good_frame_pec(d, 6'd0));
    send_request(dcpec_pkg::OP_CHECK, 1'b0, 1'b0, 1'b0, '0, d, good_frame_pec(d, 6'd5));
    send_request(dcpec_pkg::OP_CHECK, 1'b0, 1'b0, 1'b0, '0, d,
                 good_frame_pec(d, 6'd2) ^ 16'h0001);
    send_request(dcpec_pkg::OP_CHECK, 1'b1, 1'b0, 1'b1, '0, d, good_frame_pec(d, 6'd0));
    send_request(dcpec_pkg::OP_CHECK, 1'b1, 1'b1, 1'b0, '0, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_request(dcpec_pkg::OP_CHECK, 1'b0, 1'b0, 1'b1, '0, 48'h0,
                 good_frame_pec(48'h0, 6'd2));
  endtask

  // Clear a port, then advance its counter towards the wrap, past it on longer walks.
  task automatic counter_walk();
    logic p;
    p = 1'($urandom_range(0, 1));
    send_request(dcpec_pkg::OP_CLEAR, p, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 16'($urandom()), rand_data(), 16'($urandom()));
    repeat ($urandom_range(60, 70)) begin
      send_request(dcpec_pkg::OP_ADVANCE, p, ($urandom_range(0, 3) == 0),
                   1'($urandom_range(0, 1)), 16'($urandom()), rand_data(), 16'($urandom()));
    end
  endtask

  // One read set: a first frame, then more frames, mostly from the same port and mostly well formed.
  task automatic read_set();
    logic        p;
    logic [47:0] d;
    logic [5:0]  cnt;
    logic [15:0] rpec;
    int          pick;
    p = 1'($urandom_range(0, 1));
    for (int i = 0; i < $urandom_range(1, 8); i++) begin
      if ($urandom_range(0, 9) == 0) begin
        p = ~p;
      end
      d    = rand_data();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cnt = local_cnt[p];
      end else if (pick < 70) begin
        cnt = 6'd0;
      end else begin
        cnt = 6'($urandom_range(0, 63));
      end
      rpec = good_frame_pec(d, cnt);
      if ($urandom_range(0, 99) < 15) begin
        rpec = rpec ^ 16'($urandom_range(1, 16'hFFFF));
      end
      send_request(dcpec_pkg::OP_CHECK, p, 1'($urandom_range(0, 1)),
                   (i == 0) || ($urandom_range(0, 19) == 0), 16'($urandom()), d, rpec);
    end
  endtask

  // Random traffic shaped as read sets and counter walks, with PEC requests and noise.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int kind;
    logic [2:0] op;
    sent = 0;
    counter_walk();
    while (sent < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        counter_walk();
        sent += 66;
      end else if (kind < 11) begin
        read_set();
        sent += 4;
      end else if (kind < 14) begin
        op = $urandom_range(0, 1) ? dcpec_pkg::OP_ADVANCE : dcpec_pkg::OP_CLEAR;
        send_request(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 16'($urandom()), rand_data(),
                     16'($urandom()));
        sent += 1;
      end else if (kind < 17) begin
        op = $urandom_range(0, 1) ? dcpec_pkg::OP_CMD_PEC : dcpec_pkg::OP_DATA_PEC;
        send_request(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 16'($urandom()), rand_data(),
                     16'($urandom()));
        sent += 1;
      end else begin
        op = 3'($urandom_range(dcpec_pkg::OP_CMD_PEC, dcpec_pkg::OP_CLEAR));
        send_request(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 16'($urandom()), rand_data(),
                     16'($urandom()));
        sent += 1;
      end
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    pec_result_t got;
    pec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pec_result_q.size() == 0) begin
        $error("unexpected result: %0h", m_axis_tdata);
        failures++;
      end else begin
        want = pec_result_q.pop_front();
        if (got.pec_out !== want.pec_out) begin
          $error("pec_out: expected %0h, got %0h", want.pec_out, got.pec_out);
          failures++;
        end
        if (got.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
          failures++;
        end
        if (got.set_status !== want.set_status) begin
          $error("set_status: expected %0d, got %0d", want.set_status, got.set_status);
          failures++;
        end
        if (got.counter_seen !== want.counter_seen) begin
          $error("counter_seen: expected %0d, got %0d", want.counter_seen, got.counter_seen);
          failures++;
        end
        if (got.local_count !== want.local_count) begin
          $error("local_count: expected %0d, got %0d", want.local_count, got.local_count);
          failures++;
        end
        if (got.checked_data !== want.checked_data) begin
          $error("checked_data: expected %0h, got %0h", want.checked_data, got.checked_data);
          failures++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_daisy_chain_pec_unit: FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    local_cnt[0]  = 6'd0;
    local_cnt[1]  = 6'd0;
    set_stat      = dcpec_pkg::SetOk;
    send_idle_pct = 36;
    recv_idle_pct = 78;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pec_ops();
    test_counter_ops();
    test_frame_checks();
    test_random_traffic(560);
    wait_drained();

    send_idle_pct = 78;
    recv_idle_pct = 36;
    test_random_traffic(580);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(590);
    wait_drained();

    if (failures == 0) begin
      $display("tb_daisy_chain_pec_unit: PASS");
    end else begin
      $display("tb_daisy_chain_pec_unit: FAIL");
    end
    $finish;
  end

endmodule
